[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL of the hasher.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/md5sh_pkg.sv]
// ----------------------------------------------------------------------------
// md5sh_pkg
// Types, round constants and helper functions of the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5sh_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LAST_POS = 6'd63;
    localparam logic [5:0]  LEN_POS  = 6'd56;
    localparam logic [3:0]  LAST_WORD = 4'd15;
    localparam logic [3:0]  LEN_LO_WORD = 4'd14;
    localparam logic [5:0]  LAST_ROUND = 6'd63;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [5:0] ROT_AMOUNT [16] = '{
        6'd7, 6'd12, 6'd17, 6'd22, 6'd5, 6'd9, 6'd14, 6'd20,
        6'd4, 6'd11, 6'd16, 6'd23, 6'd6, 6'd10, 6'd15, 6'd21
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_SWEEP,
        ST_CMP_ISSUE,
        ST_CMP_RUN,
        ST_FOLD,
        ST_DONE
    } state_t;

    // What follows once a compression has been folded in.
    typedef enum logic [1:0] {
        CONT_IDLE,
        CONT_PAD,
        CONT_SECOND,
        CONT_DIGEST
    } cont_t;

    // Message word index used by a given round.
    function automatic logic [3:0] msg_index(input logic [5:0] round);
        logic [3:0] r4;
        logic [3:0] idx;
        r4 = round[3:0];
        case (round[5:4])
            2'd0:    idx = r4;
            2'd1:    idx = 4'((r4 << 2) + r4 + 4'd1);
            2'd2:    idx = 4'((r4 << 1) + r4 + 4'd5);
            default: idx = 4'((r4 << 3) - r4);
        endcase
        return idx;
    endfunction

    // Places a byte into lane 'lane' of a word, keeping only the lanes below it.
    function automatic logic [31:0] merge_byte(input logic [31:0] word,
                                               input logic [7:0]  value,
                                               input logic [1:0]  lane);
        logic [31:0] keep;
        case (lane)
            2'd0:    keep = 32'h0000_0000;
            2'd1:    keep = 32'h0000_00ff;
            2'd2:    keep = 32'h0000_ffff;
            default: keep = 32'h00ff_ffff;
        endcase
        return (word & keep) | ({24'd0, value} << {lane, 3'b000});
    endfunction

endpackage

[rtl/md5_stream_hasher_unit.sv]
// A byte item is taken only in the idle state, not while a block is padded,
// compressed or waiting to be output. Each completed 64-byte block holds the
// input off for a memory read set-up, 64 rounds on the single round unit and
// a fold. Closing item: a pad write, then per block still to compress a sweep
// of the remaining words and a compression, then an output load.
// Reset restores the initial chaining words and a zero bit count, not the RAM.
// ----------------------------------------------------------------------------
// md5_stream_hasher_unit
// MD5 digest of a byte stream, block buffer held in a one-port-read RAM.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module md5_stream_hasher_unit
    import md5sh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [31:0] digest_word_a,
    output logic [31:0] digest_word_b,
    output logic [31:0] digest_word_c,
    output logic [31:0] digest_word_d
);

    state_t      state_reg, state_next;
    cont_t       after_reg, after_next;
    logic [63:0] bit_count_reg, bit_count_next;
    logic [5:0]  round_reg, round_next;
    logic [3:0]  sweep_idx_reg, sweep_idx_next;
    logic        digest_valid_reg, digest_valid_next;

    logic [31:0] h0_reg, h1_reg, h2_reg, h3_reg;
    logic [31:0] h0_next, h1_next, h2_next, h3_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] out_a_reg, out_b_reg, out_c_reg, out_d_reg;
    logic        out_load;

    logic [31:0] buffer_mem [16];
    logic [31:0] buffer_rdata_reg;
    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic [3:0]  mem_raddr;

    logic        item_fire;
    logic        slot_free;
    logic [5:0]  pos;
    logic [31:0] merged_byte;
    logic [31:0] pad_word;

    logic [31:0] f_val;
    logic [31:0] round_sum;
    logic [63:0] rot_wide;
    logic [31:0] new_b;

    assign item_fire   = item_valid && item_ready;
    assign slot_free   = !digest_valid_reg || digest_ready;
    assign pos         = bit_count_reg[8:3];
    assign merged_byte = merge_byte(acc_reg, data_byte, pos[1:0]);
    assign pad_word    = merge_byte(acc_reg, PAD_BYTE, pos[1:0]);

    // One MD5 round on the working words.
    always_comb
    begin
        case (round_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        round_sum = a_reg + f_val + ROUND_K[round_reg] + buffer_rdata_reg;
        rot_wide  = {round_sum, round_sum} << ROT_AMOUNT[{round_reg[5:4], round_reg[1:0]}];
        new_b     = b_reg + rot_wide[63:32];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (byte_present && pos == LAST_POS)
                        state_next = ST_CMP_ISSUE;
                    else if (end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
                state_next = (pos[5:2] == LAST_WORD) ? ST_CMP_ISSUE : ST_SWEEP;
            ST_SWEEP:
            begin
                if (sweep_idx_reg == LAST_WORD)
                    state_next = ST_CMP_ISSUE;
            end
            ST_CMP_ISSUE:
                state_next = ST_CMP_RUN;
            ST_CMP_RUN:
            begin
                if (round_reg == LAST_ROUND)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                unique case (after_reg)
                    CONT_IDLE:   state_next = ST_IDLE;
                    CONT_PAD:    state_next = ST_PAD;
                    CONT_SECOND: state_next = ST_SWEEP;
                    CONT_DIGEST: state_next = ST_DONE;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        item_ready        = (state_reg == ST_IDLE);
        after_next        = after_reg;
        bit_count_next    = bit_count_reg;
        round_next        = round_reg;
        sweep_idx_next    = sweep_idx_reg;
        digest_valid_next = digest_valid_reg && !digest_ready;
        h0_next           = h0_reg;
        h1_next           = h1_reg;
        h2_next           = h2_reg;
        h3_next           = h3_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        c_next            = c_reg;
        d_next            = d_reg;
        acc_next          = acc_reg;
        mem_we            = 1'b0;
        mem_waddr         = pos[5:2];
        mem_wdata         = merged_byte;
        mem_raddr         = msg_index(6'd0);
        out_load          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && byte_present)
                begin
                    mem_we         = 1'b1;
                    acc_next       = merged_byte;
                    bit_count_next = bit_count_reg + 64'd8;
                    if (pos == LAST_POS)
                        after_next = end_of_message ? CONT_PAD : CONT_IDLE;
                end
            end
            ST_PAD:
            begin
                mem_we         = 1'b1;
                mem_wdata      = pad_word;
                sweep_idx_next = pos[5:2] + 4'd1;
                // No room for the length: the first final block carries only padding.
                after_next     = (pos >= LEN_POS) ? CONT_SECOND : CONT_DIGEST;
            end
            ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_idx_reg;
                if (after_reg == CONT_DIGEST && sweep_idx_reg == LEN_LO_WORD)
                    mem_wdata = bit_count_reg[31:0];
                else if (after_reg == CONT_DIGEST && sweep_idx_reg == LAST_WORD)
                    mem_wdata = bit_count_reg[63:32];
                else
                    mem_wdata = 32'd0;
                sweep_idx_next = sweep_idx_reg + 4'd1;
            end
            ST_CMP_ISSUE:
            begin
                mem_raddr  = msg_index(6'd0);
                a_next     = h0_reg;
                b_next     = h1_reg;
                c_next     = h2_reg;
                d_next     = h3_reg;
                round_next = 6'd0;
            end
            ST_CMP_RUN:
            begin
                // The read for the following round is issued alongside this one.
                mem_raddr  = msg_index(round_reg + 6'd1);
                a_next     = d_reg;
                b_next     = new_b;
                c_next     = b_reg;
                d_next     = c_reg;
                round_next = round_reg + 6'd1;
            end
            ST_FOLD:
            begin
                h0_next = h0_reg + a_reg;
                h1_next = h1_reg + b_reg;
                h2_next = h2_reg + c_reg;
                h3_next = h3_reg + d_reg;
                if (after_reg == CONT_SECOND)
                begin
                    after_next     = CONT_DIGEST;
                    sweep_idx_next = 4'd0;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_load          = 1'b1;
                    digest_valid_next = 1'b1;
                    h0_next           = INIT_A;
                    h1_next           = INIT_B;
                    h2_next           = INIT_C;
                    h3_next           = INIT_D;
                    bit_count_next    = 64'd0;
                    after_next        = CONT_IDLE;
                end
            end
            default:
            begin
                after_next = CONT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            after_reg        <= CONT_IDLE;
            bit_count_reg    <= 64'd0;
            round_reg        <= 6'd0;
            sweep_idx_reg    <= 4'd0;
            digest_valid_reg <= 1'b0;
            h0_reg           <= INIT_A;
            h1_reg           <= INIT_B;
            h2_reg           <= INIT_C;
            h3_reg           <= INIT_D;
        end
        else
        begin
            state_reg        <= state_next;
            after_reg        <= after_next;
            bit_count_reg    <= bit_count_next;
            round_reg        <= round_next;
            sweep_idx_reg    <= sweep_idx_next;
            digest_valid_reg <= digest_valid_next;
            h0_reg           <= h0_next;
            h1_reg           <= h1_next;
            h2_reg           <= h2_next;
            h3_reg           <= h3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        acc_reg <= acc_next;
        if (out_load)
        begin
            out_a_reg <= h0_reg;
            out_b_reg <= h1_reg;
            out_c_reg <= h2_reg;
            out_d_reg <= h3_reg;
        end
    end

    // Block buffer RAM: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            buffer_mem[mem_waddr] <= mem_wdata;
        buffer_rdata_reg <= buffer_mem[mem_raddr];
    end

    assign digest_valid  = digest_valid_reg;
    assign digest_word_a = out_a_reg;
    assign digest_word_b = out_b_reg;
    assign digest_word_c = out_c_reg;
    assign digest_word_d = out_d_reg;

    `ASSERT_NEXT(a_full_block_compresses, clk, rst_n, item_fire && byte_present && pos == LAST_POS, state_reg == ST_CMP_ISSUE)
    `ASSERT_NEXT(a_last_round_folds, clk, rst_n, state_reg == ST_CMP_RUN && round_reg == LAST_ROUND, state_reg == ST_FOLD)
    `ASSERT_SAME(a_fold_on_boundary, clk, rst_n, state_reg == ST_FOLD && after_reg == CONT_IDLE, bit_count_reg[8:0] == 9'd0)
    `ASSERT_NEXT(a_digest_restarts, clk, rst_n, out_load, digest_valid && bit_count_reg == 64'd0 && h0_reg == INIT_A)

endmodule
